/* src/sha1_candidate_key_generator_macros.svh */
// Assertion macros for the candidate key generator.
`ifndef SHA1_CANDIDATE_KEY_GENERATOR_MACROS_SVH
`define SHA1_CANDIDATE_KEY_GENERATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only outside reset.
`define SCKG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sckg check failed");
// Checked during reset as well.
`define SCKG_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("sckg check failed");
`else
`define SCKG_ASSERT(lbl, prop)
`define SCKG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* src/sha1ckg_pkg.sv */
`default_nettype none
package sha1ckg_pkg;

    localparam int KEY_BYTES = 7;
    localparam int KEY_USED  = (KEY_BYTES > 7) ? 7 : KEY_BYTES;
    localparam int KEY_BITS  = KEY_USED * 8;
    localparam int ROUNDS    = 80;

    localparam logic [13:0] MULT_INIT   = 14'd971;
    localparam logic [16:0] ADDA_INIT   = 17'd11113;
    localparam logic [17:0] ADDB_INIT   = 18'd104322;
    localparam logic [63:0] VALUE_INIT  = 64'd4181;
    localparam logic [13:0] MULT_STEP   = 14'd7;
    localparam logic [16:0] ADDA_STEP   = 17'd1907;
    localparam logic [18:0] ADDB_STEP   = 19'd73939;
    localparam logic [13:0] MULT_LIMIT  = 14'd9973;
    localparam logic [13:0] MULT_WRAP   = 14'd9871;
    localparam logic [16:0] ADDA_LIMIT  = 17'd99991;
    localparam logic [16:0] ADDA_WRAP   = 17'd89989;
    localparam logic [18:0] ADDB_LIMIT  = 19'd224729;
    localparam logic [18:0] ADDB_WRAP   = 19'd96233;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    // Generator output beat.
    typedef struct packed {
        logic        valid;
        logic [31:0] idx;
        logic [63:0] value;
    } gen_beat_t;

    // Data handed from one round cell to the next.
    typedef struct packed {
        logic             valid;
        logic [31:0]      idx;
        logic [63:0]      value;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      c;
        logic [31:0]      d;
        logic [31:0]      e;
        logic [15:0][31:0] w;
    } cell_state_t;

    function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20)      f = (b & c) | (~b & d);
        else if (rnd < 7'd40) f = b ^ c ^ d;
        else if (rnd < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                  f = b ^ c ^ d;
        return f;
    endfunction

    function automatic logic [31:0] round_k(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20)      k = 32'h5A827999;
        else if (rnd < 7'd40) k = 32'h6ED9EBA1;
        else if (rnd < 7'd60) k = 32'h8F1BBCDC;
        else                  k = 32'hCA62C1D6;
        return k;
    endfunction

endpackage
`default_nettype wire

/* src/sha1ckg_gen.sv */
`default_nettype none
module sha1ckg_gen
    import sha1ckg_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire logic        step,
    input  wire logic        restart,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_data,
    output gen_beat_t        beat
);

    logic [63:0] seed_plus_reg;
    logic [13:0] mult_reg, mult_next, mult_base;
    logic [16:0] adda_reg, adda_next, adda_base, adda_sum;
    logic [17:0] addb_reg, addb_next, addb_base;
    logic [18:0] addb_sum;
    logic [13:0] mult_sum;
    logic [63:0] value_reg, value_next, value_base, prod;
    logic [31:0] cnt_reg, cnt_next, idx_cur;
    gen_beat_t   beat_reg;

    always_comb begin
        mult_base  = restart ? MULT_INIT : mult_reg;
        adda_base  = restart ? ADDA_INIT : adda_reg;
        addb_base  = restart ? ADDB_INIT : addb_reg;
        value_base = restart ? seed_plus_reg : value_reg;
        idx_cur    = restart ? 32'd0 : cnt_reg;

        mult_sum = mult_base + MULT_STEP;
        adda_sum = adda_base + ADDA_STEP;
        addb_sum = {1'b0, addb_base} + ADDB_STEP;
        mult_next = (mult_sum >= MULT_LIMIT) ? mult_sum - MULT_WRAP : mult_sum;
        adda_next = (adda_sum >= ADDA_LIMIT) ? adda_sum - ADDA_WRAP : adda_sum;
        addb_next = (addb_sum >= ADDB_LIMIT) ? 18'(addb_sum - ADDB_WRAP) : 18'(addb_sum);

        prod       = value_base * {50'd0, mult_next};
        value_next = prod + {47'd0, adda_next} + {46'd0, addb_next};
        cnt_next   = idx_cur + 32'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_plus_reg  <= VALUE_INIT;
            mult_reg       <= MULT_INIT;
            adda_reg       <= ADDA_INIT;
            addb_reg       <= ADDB_INIT;
            value_reg      <= VALUE_INIT;
            cnt_reg        <= 32'd0;
            beat_reg.valid <= 1'b0;
        end else begin
            if (cfg_we) begin
                seed_plus_reg <= cfg_data + VALUE_INIT;
            end
            if (step) begin
                mult_reg  <= mult_next;
                adda_reg  <= adda_next;
                addb_reg  <= addb_next;
                value_reg <= value_next;
                cnt_reg   <= cnt_next;
            end
            if (advance) begin
                beat_reg.valid <= step;
            end
        end
        if (advance) begin
            beat_reg.idx   <= idx_cur;
            beat_reg.value <= value_next;
        end
    end

    assign beat = beat_reg;

endmodule
`default_nettype wire

/* src/sha1ckg_round.sv */
`default_nettype none
module sha1ckg_round
    import sha1ckg_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  wire logic [6:0] rnd,
    input  wire cell_state_t cell_in,
    output cell_state_t cell_out
);

    cell_state_t state_reg, state_next;
    logic [31:0] t, x;

    always_comb begin
        t = {cell_in.a[26:0], cell_in.a[31:27]} + round_f(rnd, cell_in.b, cell_in.c, cell_in.d)
          + cell_in.e + round_k(rnd) + cell_in.w[0];
        // w[j] = rotl1(w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16])
        x = cell_in.w[13] ^ cell_in.w[8] ^ cell_in.w[2] ^ cell_in.w[0];
        state_next       = cell_in;
        state_next.a     = t;
        state_next.b     = cell_in.a;
        state_next.c     = {cell_in.b[1:0], cell_in.b[31:2]};
        state_next.d     = cell_in.c;
        state_next.e     = cell_in.d;
        state_next.w     = {{x[30:0], x[31]}, cell_in.w[15:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.valid <= 1'b0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign cell_out = state_reg;

endmodule
`default_nettype wire

/* src/sha1_candidate_key_generator.sv */
// SHA-1 candidate key generator for a truncated-digest birthday search.
// Input channel s_*: one beat per candidate; s_tdata[0] is the restart flag,
// which reloads the generator from the seed and zeroes the item index first.
// Output channel m_*: one beat per input beat, in order: index, generator
// value, the five SHA-1 digest words of its 16-letter spelling, and the key.
// Config channel cfg_*: always ready; writes the 64-bit seed. Write it only
// while no beat is in flight.
// Path to m_tvalid: the generator register loads at the accepting edge, then
// 80 round cells and the digest/key output register. Throughput: one beat
// per cycle while m_tready does not stall the output; the only serial part
// is the 64x14 generator multiply-add.
// Reset clears every valid bit and restores the generator as after a
// restart with seed 0. When the receiver stalls, the whole chain freezes
// and s_tready drops in the same cycle, so nothing is lost or repeated.
`default_nettype none
`include "sha1_candidate_key_generator_macros.svh"
module sha1_candidate_key_generator
    import sha1ckg_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [0] restart, [7:1] zero
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [31:0] item_number, [95:32] candidate_value, [127:96] digest_word0,
    // [159:128] digest_word1, [191:160] digest_word2, [223:192] digest_word3,
    // [255:224] digest_word4, [311:256] search_key
    output logic [311:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [63:0]  cfg_data
);

    logic        advance;
    logic        step;
    gen_beat_t   gen_beat;
    cell_state_t chain [ROUNDS+1];
    logic        out_valid_reg;
    logic [311:0] out_data_reg;
    logic [159:0] digest;
    logic [55:0]  key;

    // Whole pipeline moves together unless the output beat is held.
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = advance;
    assign step      = s_tvalid && advance;
    assign cfg_ready = 1'b1;

    sha1ckg_gen u_gen (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .step     (step),
        .restart  (s_tdata[0]),
        .cfg_we   (cfg_valid),
        .cfg_data (cfg_data),
        .beat     (gen_beat)
    );

    // Message block: 16 letters 'a'+nibble, then 0x80 pad, length 128 bits.
    always_comb begin
        chain[0].valid = gen_beat.valid;
        chain[0].idx   = gen_beat.idx;
        chain[0].value = gen_beat.value;
        chain[0].a     = H0_INIT;
        chain[0].b     = H1_INIT;
        chain[0].c     = H2_INIT;
        chain[0].d     = H3_INIT;
        chain[0].e     = H4_INIT;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                chain[0].w[i][31-8*j -: 8] =
                    8'h61 + {4'd0, gen_beat.value[63-16*i-4*j -: 4]};
            end
        end
        chain[0].w[4] = 32'h80000000;
        for (int i = 5; i < 15; i++) begin
            chain[0].w[i] = 32'd0;
        end
        chain[0].w[15] = 32'd128;
    end

    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        sha1ckg_round u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .rnd      (7'(r)),
            .cell_in  (chain[r]),
            .cell_out (chain[r+1])
        );
    end

    // Digest bytes 0..19 big-endian; key is the trailing bytes.
    always_comb begin
        digest = {chain[ROUNDS].a + H0_INIT, chain[ROUNDS].b + H1_INIT,
                  chain[ROUNDS].c + H2_INIT, chain[ROUNDS].d + H3_INIT,
                  chain[ROUNDS].e + H4_INIT};
        key    = 56'(digest[KEY_BITS-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= chain[ROUNDS].valid;
        end
        if (advance) begin
            out_data_reg <= {key, digest[31:0], digest[63:32], digest[95:64],
                             digest[127:96], digest[159:128],
                             chain[ROUNDS].value, chain[ROUNDS].idx};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SCKG_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid)
    `SCKG_ASSERT(a_stall_freezes_gen, (m_tvalid && !m_tready) |=> $stable(gen_beat))
    `SCKG_ASSERT(a_no_accept_on_stall, (m_tvalid && !m_tready) |-> !s_tready)

endmodule
`default_nettype wire
